[rtl/tnd_pkg.sv]
// Shared constants, phase codes and the compare unit result type for neighbour discovery.
package tnd_pkg;

  localparam int unsigned MAX_NEIGHBORS_DEF = 16;
  localparam int unsigned ADDR_BITS_DEF     = 8;

  localparam int unsigned TICK_W      = 32;
  localparam int unsigned SRC_W       = 8;
  localparam int unsigned CNT_OUT_W   = 5;
  localparam int unsigned PHASE_W     = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;

  localparam logic [TICK_W-1:0] WINDOW_RST = 32'd1024;
  localparam logic [TICK_W-1:0] OFFSET_RST = 32'd32;

  // discovery phases
  localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_ACTIVE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DONE   = 2'd2;

  typedef struct packed {
    logic [TICK_W-1:0] sum_sat;  // a + b, saturated at all ones
    logic              ge;       // c >= a + b, 33-bit
    logic              gt;       // c >  a + b, 33-bit
    logic              eq;       // c == a + b, 33-bit
  } alu_res_t;

endpackage

[rtl/timed_neighbor_discovery_core.sv]
// Timed beacon neighbour discovery: poll sequencer, shared compare unit and neighbour RAM.
// Polls in done phase go straight to the result; other polls pass the window and beacon checks,
//   and a frame then adds a scan of the stored neighbours plus an append if the source is new.
// A new poll is taken only once the sequencer is back in idle, so the neighbour scan sets the rate.
// The result sits in an output register, so the next poll is taken while it waits.
// Reset: asynchronous, active low; clears phase, start, beacon time, count and registers.
module timed_neighbor_discovery_core #(
  parameter int unsigned MAX_NEIGHBORS = tnd_pkg::MAX_NEIGHBORS_DEF,
  parameter int unsigned ADDR_BITS     = tnd_pkg::ADDR_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [tnd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tnd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // poll input
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [tnd_pkg::TICK_W-1:0]         now_tick_i,
  input  logic                               rx_valid_i,
  input  logic [tnd_pkg::SRC_W-1:0]          rx_src_i,
  // result
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [tnd_pkg::PHASE_W-1:0]        phase_o,
  output logic                               send_beacon_o,
  output logic [tnd_pkg::CNT_OUT_W-1:0]      neighbor_count_o,
  output logic                               neighbor_added_o,
  output logic                               table_full_drop_o
);

  localparam int unsigned CNT_W = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int unsigned TW    = tnd_pkg::TICK_W;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NEIGHBORS);

  localparam int unsigned ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] S_START  = 4'd1;
  localparam logic [ST_W-1:0] S_WIN    = 4'd2;
  localparam logic [ST_W-1:0] S_BCHK   = 4'd3;
  localparam logic [ST_W-1:0] S_BSET   = 4'd4;
  localparam logic [ST_W-1:0] S_RX     = 4'd5;
  localparam logic [ST_W-1:0] S_SCAN   = 4'd6;
  localparam logic [ST_W-1:0] S_APPEND = 4'd7;
  localparam logic [ST_W-1:0] S_FIN    = 4'd8;

  logic [ST_W-1:0] state_q, state_d;

  logic [TW-1:0] window_q, offset_q;

  logic [TW-1:0]        now_q;
  logic                 rx_q;
  logic [ADDR_BITS-1:0] key_q;
  logic [ADDR_BITS+tnd_pkg::SRC_W-1:0] src_ext;

  logic                        started_q, started_d;
  logic [TW-1:0]               start_tick_q, start_tick_d;
  logic [TW-1:0]               next_beacon_q, next_beacon_d;
  logic [tnd_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [CNT_W-1:0]            idx_q, idx_d, idx_nx;
  logic                        beacon_q, beacon_d;
  logic                        added_q, added_d;
  logic                        dropped_q, dropped_d;

  logic                                out_valid_q, out_valid_d;
  logic [tnd_pkg::PHASE_W-1:0]         out_phase_q;
  logic                                out_beacon_q, out_added_q, out_dropped_q;
  logic [tnd_pkg::CNT_OUT_W-1:0]       out_count_q;
  logic [CNT_W+tnd_pkg::CNT_OUT_W-1:0] cnt_ext;
  logic                                out_load;

  logic [TW-1:0]     alu_a, alu_b, alu_c;
  tnd_pkg::alu_res_t alu_res;

  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_rdata;

  logic in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign src_ext    = {{ADDR_BITS{1'b0}}, rx_src_i};
  assign idx_nx     = idx_q + CNT_W'(1);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= tnd_pkg::WINDOW_RST;
      offset_q <= tnd_pkg::OFFSET_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == tnd_pkg::REG_WINDOW) begin
        window_q <= cfg_wdata_i;
      end else if (cfg_idx_i == tnd_pkg::REG_OFFSET) begin
        offset_q <= cfg_wdata_i;
      end
    end
  end

  // poll beat capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      now_q <= now_tick_i;
      rx_q  <= rx_valid_i;
      key_q <= src_ext[ADDR_BITS-1:0];
    end
  end

  // operand selection for the shared unit
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    alu_c = '0;
    unique case (state_q)
      S_START, S_BSET: begin
        alu_a = now_q;
        alu_b = offset_q;
      end
      S_WIN: begin
        alu_a = start_tick_q;
        alu_b = window_q;
        alu_c = now_q;
      end
      S_BCHK: begin
        alu_a = next_beacon_q;
        alu_c = now_q;
      end
      S_SCAN: begin
        alu_a = TW'(ram_rdata);
        alu_c = TW'(key_q);
      end
      default: begin
      end
    endcase
  end

  tnd_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .c_i   (alu_c),
    .res_o (alu_res)
  );

  tnd_ram #(
    .WIDTH (ADDR_BITS),
    .DEPTH (MAX_NEIGHBORS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (key_q),
    .raddr_i (idx_d[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_d       = state_q;
    started_d     = started_q;
    start_tick_d  = start_tick_q;
    next_beacon_d = next_beacon_q;
    phase_d       = phase_q;
    count_d       = count_q;
    idx_d         = idx_q;
    beacon_d      = beacon_q;
    added_d       = added_q;
    dropped_d     = dropped_q;
    ram_we        = 1'b0;
    out_load      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          beacon_d  = 1'b0;
          added_d   = 1'b0;
          dropped_d = 1'b0;
          state_d   = S_START;
        end
      end
      S_START: begin
        if (!started_q) begin
          started_d     = 1'b1;
          start_tick_d  = now_q;
          next_beacon_d = alu_res.sum_sat;
        end
        state_d = S_WIN;
      end
      S_WIN: begin
        if (alu_res.ge) begin
          phase_d = tnd_pkg::PH_DONE;
          state_d = S_FIN;
        end else if (phase_q == tnd_pkg::PH_IDLE) begin
          state_d = S_BCHK;
        end else begin
          // active, or done with ticks gone backwards: drop back to idle
          phase_d = tnd_pkg::PH_IDLE;
          state_d = S_RX;
        end
      end
      S_BCHK: begin
        if (alu_res.gt) begin
          phase_d  = tnd_pkg::PH_ACTIVE;
          beacon_d = 1'b1;
          state_d  = S_BSET;
        end else begin
          state_d = S_RX;
        end
      end
      S_BSET: begin
        next_beacon_d = alu_res.sum_sat;
        state_d       = S_RX;
      end
      S_RX: begin
        idx_d = '0;
        if (!rx_q) begin
          state_d = S_FIN;
        end else if (count_q == '0) begin
          state_d = S_APPEND;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (alu_res.eq) begin
          state_d = S_FIN;
        end else if (idx_nx == count_q) begin
          state_d = S_APPEND;
        end else begin
          idx_d = idx_nx;
        end
      end
      S_APPEND: begin
        if (count_q < CNT_MAX) begin
          ram_we  = 1'b1;
          count_d = count_q + CNT_W'(1);
          added_d = 1'b1;
        end else begin
          dropped_d = 1'b1;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      started_q     <= 1'b0;
      start_tick_q  <= '0;
      next_beacon_q <= '0;
      phase_q       <= tnd_pkg::PH_IDLE;
      count_q       <= '0;
      idx_q         <= '0;
      beacon_q      <= 1'b0;
      added_q       <= 1'b0;
      dropped_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      started_q     <= started_d;
      start_tick_q  <= start_tick_d;
      next_beacon_q <= next_beacon_d;
      phase_q       <= phase_d;
      count_q       <= count_d;
      idx_q         <= idx_d;
      beacon_q      <= beacon_d;
      added_q       <= added_d;
      dropped_q     <= dropped_d;
    end
  end

  // output register
  assign cnt_ext     = {{tnd_pkg::CNT_OUT_W{1'b0}}, count_q};
  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_phase_q   <= phase_q;
      out_beacon_q  <= beacon_q;
      out_count_q   <= cnt_ext[tnd_pkg::CNT_OUT_W-1:0];
      out_added_q   <= added_q;
      out_dropped_q <= dropped_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign phase_o           = out_phase_q;
  assign send_beacon_o     = out_beacon_q;
  assign neighbor_count_o  = out_count_q;
  assign neighbor_added_o  = out_added_q;
  assign table_full_drop_o = out_dropped_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX)
    else $error("neighbour count above table depth");

  a_add_xor_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |-> !(added_q && dropped_q))
    else $error("source both appended and dropped");

  a_done_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && phase_q == tnd_pkg::PH_DONE) |-> !beacon_q && !added_q && !dropped_q)
    else $error("flag raised in done phase");

  a_append_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("append did not advance the count");

  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_START)
    else $error("accepted beat did not start the sequence");

endmodule

[rtl/tnd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tnd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tnd_alu.sv]
// Shared 33-bit add and compare unit used by the start, window, beacon and scan steps of the sequencer.
module tnd_alu (
  input  logic [tnd_pkg::TICK_W-1:0] a_i,
  input  logic [tnd_pkg::TICK_W-1:0] b_i,
  input  logic [tnd_pkg::TICK_W-1:0] c_i,
  output tnd_pkg::alu_res_t          res_o
);

  logic [tnd_pkg::TICK_W:0] sum;
  logic [tnd_pkg::TICK_W:0] c_ext;

  always_comb begin
    sum   = {1'b0, a_i} + {1'b0, b_i};
    c_ext = {1'b0, c_i};
    res_o.sum_sat = sum[tnd_pkg::TICK_W] ? '1 : sum[tnd_pkg::TICK_W-1:0];
    res_o.ge      = (c_ext >= sum);
    res_o.gt      = (c_ext >  sum);
    res_o.eq      = (c_ext == sum);
  end

endmodule
